// ----- rtl/xms_handle_manager_macros.svh -----
// assertion macros for the handle manager checker
`ifndef XMS_HANDLE_MANAGER_MACROS_SVH
`define XMS_HANDLE_MANAGER_MACROS_SVH

// implication checked every clock, off during reset
`define XMS_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("xms check failed");

// next-cycle implication
`define XMS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("xms check failed");

`endif

// ----- rtl/xms_pkg.sv -----
// ----------------------------------------------------------------------------
// xms_pkg
// shared types and constants of the extended-memory handle manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package xms_pkg;

  localparam int unsigned InW  = 72;
  localparam int unsigned OutW = 88;

  typedef enum logic [4:0] {
    MODE_INIT = 5'd0, MODE_HMA_REQ = 5'd1, MODE_HMA_REL = 5'd2,
    MODE_A20_GEN = 5'd3, MODE_A20_GDIS = 5'd4, MODE_A20_LEN = 5'd5,
    MODE_A20_LDIS = 5'd6, MODE_A20_QRY = 5'd7, MODE_QFREE = 5'd8,
    MODE_ALLOC = 5'd9, MODE_FREE = 5'd10, MODE_LOCK = 5'd11,
    MODE_UNLOCK = 5'd12, MODE_INFO = 5'd13, MODE_RESIZE = 5'd14,
    MODE_UMB_REQ = 5'd15, MODE_UMB_REL = 5'd16
  } mode_e;

  localparam logic [3:0] ErrNone = 4'd0;
  localparam logic [3:0] ErrUnimpl = 4'd1;
  localparam logic [3:0] ErrHmaUsed = 4'd2;
  localparam logic [3:0] ErrHmaFree = 4'd3;
  localparam logic [3:0] ErrNoHandles = 4'd4;
  localparam logic [3:0] ErrBadHandle = 4'd5;
  localparam logic [3:0] ErrLocked = 4'd6;
  localparam logic [3:0] ErrSmallerUmb = 4'd7;
  localparam logic [3:0] ErrNoUmb = 4'd8;
  localparam logic [3:0] ErrBadUmb = 4'd9;

  localparam logic [1:0] RegTotalKb = 2'd0;
  localparam logic [1:0] RegUmbA = 2'd1;
  localparam logic [1:0] RegUmbCf = 2'd2;

  localparam logic [15:0] SegC000 = 16'hC000;
  localparam logic [15:0] SegA000 = 16'hA000;
  localparam logic [15:0] SegF000 = 16'hF000;
  localparam logic [15:0] SegD000 = 16'hD000;
  localparam logic [11:0] UmbMax = 12'hFFF;

  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] handle;
    logic [15:0] size_kb;
    logic [15:0] umb_paragraphs;
    logic [15:0] segment;
  } req_t;

  typedef struct packed {
    logic [11:0] umb_max_paragraphs;
    logic [15:0] umb_segment;
    logic        a20_on;
    logic [15:0] size_kb_out;
    logic [5:0]  free_handles;
    logic [7:0]  lock_count_out;
    logic [15:0] free_kb;
    logic [5:0]  handle_out;
    logic [3:0]  error_code;
    logic        success;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic scan;     // run one scan step
    logic finish;   // apply the request, build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/xms_datapath.sv -----
// ----------------------------------------------------------------------------
// xms_datapath
// handle table, scalar state and per-request scan over the table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xms_datapath
  import xms_pkg::*;
#(
  parameter int unsigned Handles = 32,
  parameter int unsigned IdxW = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire req_t        req_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output rsp_t             rsp_o
);

  // configuration registers
  logic [15:0] total_kb_q;
  logic        umb_a_en_q, umb_cf_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_kb_q  <= 16'd8192;
      umb_a_en_q  <= 1'b1;
      umb_cf_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTotalKb: total_kb_q <= cfg_data_i;
        RegUmbA:    umb_a_en_q <= cfg_data_i[0];
        RegUmbCf:   umb_cf_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // table: valid bits in flops, sizes and locks in memories
  logic [Handles:1] valid_q;
  logic [15:0] size_mem [1:Handles];
  logic [7:0]  lock_mem [1:Handles];

  req_t        req_q;
  logic [IdxW-1:0] ptr_q;      // scan pointer
  logic [IdxW-1:0] first_q;    // first free handle, zero if none
  logic [22:0] sum_q;
  logic [15:0] hsize_q;
  logic [7:0]  hlock_q;
  logic        hvalid_q;
  logic [IdxW-1:0] used_q;
  logic        hma_free_q;
  logic [7:0]  a20_q;
  logic [3:0]  umb_q;
  rsp_t        rsp_q;

  logic hin;
  logic [IdxW-1:0] hidx;
  assign hin  = (req_q.handle != 16'd0) && (req_q.handle <= 16'(Handles));
  assign hidx = req_q.handle[IdxW-1:0];

  assign sts_o.scan_done = (ptr_q == IdxW'(Handles));

  // scan registers and sequential table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      ptr_q   <= IdxW'(1);
      first_q <= '0;
      sum_q   <= '0;
    end else if (cmd_i.scan) begin
      if (!valid_q[ptr_q] && first_q == '0) first_q <= ptr_q;
      if (valid_q[ptr_q]) sum_q <= sum_q + 23'(size_mem[ptr_q]);
      if (!sts_o.scan_done) ptr_q <= ptr_q + IdxW'(1);
    end
    if (cmd_i.scan && hin) begin
      hsize_q <= size_mem[hidx];
      hlock_q <= lock_mem[hidx];
    end
    hvalid_q <= hin && valid_q[hidx];
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      case (req_q.mode)
        MODE_ALLOC: if (first_q != '0) begin
          size_mem[first_q] <= req_q.size_kb;
          lock_mem[first_q] <= 8'd0;
        end
        MODE_LOCK: if (hvalid_q && hlock_q != 8'hFF) lock_mem[hidx] <= hlock_q + 8'd1;
        MODE_UNLOCK: if (hvalid_q && hlock_q != 8'd0) lock_mem[hidx] <= hlock_q - 8'd1;
        MODE_RESIZE: if (hvalid_q && hlock_q == 8'd0) size_mem[hidx] <= req_q.size_kb;
        default: ;
      endcase
    end
  end

  // state update and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      used_q     <= '0;
      hma_free_q <= 1'b1;
      a20_q      <= '0;
      umb_q      <= 4'b1111;
      rsp_q      <= '0;
    end else if (cmd_i.finish) begin
      rsp_t r;
      logic [3:0] u;
      logic [7:0] a;
      r = '0;
      u = umb_q;
      a = a20_q;
      case (req_q.mode)
        MODE_INIT: begin
          valid_q <= '0; used_q <= '0; hma_free_q <= 1'b1; a = '0;
          u = {1'b1, umb_cf_en_q, umb_a_en_q, umb_cf_en_q};
          r.success = 1'b1;
        end
        MODE_HMA_REQ: if (hma_free_q) begin
          hma_free_q <= 1'b0; r.success = 1'b1;
        end else r.error_code = ErrHmaUsed;
        MODE_HMA_REL: if (!hma_free_q) begin
          hma_free_q <= 1'b1; r.success = 1'b1;
        end else r.error_code = ErrHmaFree;
        MODE_A20_GEN:  begin a = 8'd1; r.success = 1'b1; end
        MODE_A20_GDIS: begin a = 8'd0; r.success = 1'b1; end
        MODE_A20_LEN:  begin if (a != 8'hFF) a = a + 8'd1; r.success = 1'b1; end
        MODE_A20_LDIS: begin if (a != 8'd0) a = a - 8'd1; r.success = 1'b1; end
        MODE_A20_QRY:  r.success = 1'b1;
        MODE_QFREE: begin
          r.free_kb = (sum_q >= 23'(total_kb_q)) ? 16'd0 : 16'(23'(total_kb_q) - sum_q);
          r.success = 1'b1;
        end
        MODE_ALLOC: if (first_q != '0) begin
          valid_q[first_q] <= 1'b1;
          used_q <= used_q + IdxW'(1);
          r.handle_out = 6'(first_q);
          r.success = 1'b1;
        end else r.error_code = ErrNoHandles;
        MODE_FREE: if (hvalid_q) begin
          valid_q[hidx] <= 1'b0;
          if (used_q != '0) used_q <= used_q - IdxW'(1);
          r.success = 1'b1;
        end else r.error_code = ErrBadHandle;
        MODE_LOCK, MODE_UNLOCK: if (hvalid_q) r.success = 1'b1;
          else r.error_code = ErrBadHandle;
        MODE_INFO: begin
          r.free_handles = (used_q >= IdxW'(Handles)) ? 6'd0 : 6'(IdxW'(Handles) - used_q);
          if (hvalid_q) begin
            r.lock_count_out = hlock_q; r.size_kb_out = hsize_q; r.success = 1'b1;
          end else r.error_code = ErrBadHandle;
        end
        MODE_RESIZE: if (!hvalid_q) r.error_code = ErrBadHandle;
          else if (hlock_q != 8'd0) r.error_code = ErrLocked;
          else r.success = 1'b1;
        MODE_UMB_REQ: begin
          if (req_q.umb_paragraphs > 16'h0FFF && u != 4'd0) begin
            r.error_code = ErrSmallerUmb; r.umb_max_paragraphs = UmbMax;
          end else if (u[0]) begin u[0] = 1'b0; r.umb_segment = SegC000; r.success = 1'b1;
          end else if (u[1]) begin u[1] = 1'b0; r.umb_segment = SegA000; r.success = 1'b1;
          end else if (u[2]) begin u[2] = 1'b0; r.umb_segment = SegF000; r.success = 1'b1;
          end else if (u[3]) begin u[3] = 1'b0; r.umb_segment = SegD000; r.success = 1'b1;
          end else r.error_code = ErrNoUmb;
        end
        MODE_UMB_REL: begin
          if (!u[0] && req_q.segment == SegC000) begin u[0] = 1'b1; r.success = 1'b1;
          end else if (!u[1] && req_q.segment == SegA000) begin u[1] = 1'b1; r.success = 1'b1;
          end else if (!u[2] && req_q.segment == SegF000) begin u[2] = 1'b1; r.success = 1'b1;
          end else if (!u[3] && req_q.segment == SegD000) begin u[3] = 1'b1; r.success = 1'b1;
          end else r.error_code = ErrBadUmb;
        end
        default: r.error_code = ErrUnimpl;
      endcase
      r.a20_on = (a != 8'd0);
      umb_q <= u;
      a20_q <= a;
      rsp_q <= r;
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// ----- rtl/xms_ctrl.sv -----
// ----------------------------------------------------------------------------
// xms_ctrl
// request sequencer: load, table scan, apply, hold result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module xms_ctrl
  import xms_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_e;
  state_e state_q;
  logic   out_valid_q;

  // a new request is taken only in idle, and only when no result waits or the waiting one is taken
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.finish = (state_q == S_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_SCAN;
        S_SCAN: if (sts_i.scan_done) state_q <= S_FIN;
        S_FIN: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/xms_handle_manager.sv -----
// ----------------------------------------------------------------------------
// xms_handle_manager
// extended-memory driver request engine with a handle table
// ----------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   tdata: mode, handle, size_kb, umb_paragraphs, segment
// m_axis    out  tdata: result fields, one per request
// cfg       in   we, index, data: total_kb, umb_a000, umb_c000_f000
// each request is loaded, then scanned with one table entry read per cycle,
// then applied in the finish state, which loads the result register, and the
// next request is taken once the sequencer is back in idle.
// a result waits in the output register and holds off the next request.
// reset restores defaults; the table needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module xms_handle_manager
  import xms_pkg::*;
#(
  parameter int unsigned Handles = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // mode[4:0], handle[20:5], size_kb[36:21], umb_paragraphs[52:37], segment[68:53]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // success, error_code, handle_out, free_kb, lock_count_out, free_handles,
  // size_kb_out, a20_on, umb_segment, umb_max_paragraphs (low bit first)
  output logic [87:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(Handles + 1);

  cmd_t cmd;
  sts_t sts;
  req_t req;
  rsp_t rsp;

  assign req.mode           = s_axis_tdata[4:0];
  assign req.handle         = s_axis_tdata[20:5];
  assign req.size_kb        = s_axis_tdata[36:21];
  assign req.umb_paragraphs = s_axis_tdata[52:37];
  assign req.segment        = s_axis_tdata[68:53];

  xms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts)
  );

  xms_datapath #(.Handles(Handles), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_i(req),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .rsp_o(rsp)
  );

  assign m_axis_tdata = {2'b0, rsp};

endmodule
`default_nettype wire

// ----- rtl/xms_checker.sv -----
// ----------------------------------------------------------------------------
// xms_checker
// port-level checks on the handle manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "xms_handle_manager_macros.svh"
module xms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata
);
  // stalled result holds
  `XMS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // no result appears right after a request
  `XMS_ASSERT_NEXT(a_lat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))
  // success never carries an error code
  `XMS_ASSERT_IMP(a_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[4:1] == 4'd0)
endmodule

bind xms_handle_manager xms_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ----- dv/xms_handle_manager_tb.sv -----
// ----------------------------------------------------------------------------
// xms_handle_manager_tb
// self-checking bench: directed table then constrained-by-hand random
// requests, every result compared field by field with a behavioral predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module xms_handle_manager_tb;
  import xms_pkg::*;

  localparam int unsigned NumHandles = 32;
  localparam int unsigned ReqCycles = NumHandles + 3;
  localparam int unsigned IdleLimit = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // mode, handle, size_kb, umb_paragraphs, segment (low bit first)
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // success, error_code, handle_out, free_kb, lock_count_out, free_handles,
  // size_kb_out, a20_on, umb_segment, umb_max_paragraphs (low bit first)
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  xms_handle_manager #(.Handles(NumHandles)) u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i
  );

  // predictor state
  bit          tbl_valid [1:NumHandles];
  logic [15:0] tbl_size [1:NumHandles];
  logic [7:0]  tbl_locks [1:NumHandles];
  int unsigned used_cnt;
  bit          hma_avail;
  int unsigned a20_depth;
  logic [3:0]  umb_avail;  // bit0 C000, bit1 A000, bit2 F000, bit3 D000
  logic [15:0] total_kb_r;
  bit          umb_a_en;
  bit          umb_cf_en;

  rsp_t        pending_rsp[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;

  typedef struct {
    logic [4:0]  mode;
    logic [15:0] handle;
    logic [15:0] size_kb;
    logic [15:0] paras;
    logic [15:0] seg;
    bit          typed;
    bit          ok;
    logic [3:0]  err;
  } dir_row_t;

  function automatic void table_init();
    for (int i = 1; i <= NumHandles; i++) begin
      tbl_valid[i] = 0;
      tbl_size[i] = '0;
      tbl_locks[i] = '0;
    end
    used_cnt = 0;
    hma_avail = 1;
    a20_depth = 0;
    umb_avail = {1'b1, umb_cf_en, umb_a_en, umb_cf_en};
  endfunction

  function automatic bit live_handle(logic [15:0] h);
    return h >= 1 && h <= NumHandles && tbl_valid[h];
  endfunction

  // apply one request to the predictor state and build its result
  function automatic rsp_t serve_request(logic [4:0] mode, logic [15:0] h,
                                         logic [15:0] sz, logic [15:0] paras,
                                         logic [15:0] seg);
    rsp_t r;
    int unsigned sum;
    int unsigned slot;
    r = '0;
    case (mode)
      MODE_INIT: begin
        table_init();
        r.success = 1;
      end
      MODE_HMA_REQ: begin
        if (hma_avail) begin
          hma_avail = 0;
          r.success = 1;
        end else r.error_code = ErrHmaUsed;
      end
      MODE_HMA_REL: begin
        if (hma_avail) r.error_code = ErrHmaFree;
        else begin
          hma_avail = 1;
          r.success = 1;
        end
      end
      MODE_A20_GEN: begin a20_depth = 1; r.success = 1; end
      MODE_A20_GDIS: begin a20_depth = 0; r.success = 1; end
      MODE_A20_LEN: begin
        if (a20_depth < 255) a20_depth++;
        r.success = 1;
      end
      MODE_A20_LDIS: begin
        if (a20_depth > 0) a20_depth--;
        r.success = 1;
      end
      MODE_A20_QRY: r.success = 1;
      MODE_QFREE: begin
        sum = 0;
        for (int i = 1; i <= NumHandles; i++) if (tbl_valid[i]) sum += tbl_size[i];
        r.free_kb = (sum >= total_kb_r) ? 16'd0 : 16'(total_kb_r - sum);
        r.success = 1;
      end
      MODE_ALLOC: begin
        slot = 0;
        for (int i = NumHandles; i >= 1; i--) if (!tbl_valid[i]) slot = i;
        if (slot == 0) r.error_code = ErrNoHandles;
        else begin
          tbl_valid[slot] = 1;
          tbl_size[slot] = sz;
          tbl_locks[slot] = '0;
          used_cnt++;
          r.handle_out = 6'(slot);
          r.success = 1;
        end
      end
      MODE_FREE: begin
        if (!live_handle(h)) r.error_code = ErrBadHandle;
        else begin
          tbl_valid[h] = 0;
          if (used_cnt > 0) used_cnt--;
          r.success = 1;
        end
      end
      MODE_LOCK: begin
        if (!live_handle(h)) r.error_code = ErrBadHandle;
        else begin
          if (tbl_locks[h] != 8'hFF) tbl_locks[h]++;
          r.success = 1;
        end
      end
      MODE_UNLOCK: begin
        if (!live_handle(h)) r.error_code = ErrBadHandle;
        else begin
          if (tbl_locks[h] != 0) tbl_locks[h]--;
          r.success = 1;
        end
      end
      MODE_INFO: begin
        r.free_handles = (used_cnt >= NumHandles) ? 6'd0 : 6'(NumHandles - used_cnt);
        if (!live_handle(h)) r.error_code = ErrBadHandle;
        else begin
          r.lock_count_out = tbl_locks[h];
          r.size_kb_out = tbl_size[h];
          r.success = 1;
        end
      end
      MODE_RESIZE: begin
        if (!live_handle(h)) r.error_code = ErrBadHandle;
        else if (tbl_locks[h] != 0) r.error_code = ErrLocked;
        else begin
          tbl_size[h] = sz;
          r.success = 1;
        end
      end
      MODE_UMB_REQ: begin
        if (paras > 16'h0FFF && umb_avail != 0) begin
          r.error_code = ErrSmallerUmb;
          r.umb_max_paragraphs = UmbMax;
        end else if (umb_avail[0]) begin
          umb_avail[0] = 0; r.umb_segment = SegC000; r.success = 1;
        end else if (umb_avail[1]) begin
          umb_avail[1] = 0; r.umb_segment = SegA000; r.success = 1;
        end else if (umb_avail[2]) begin
          umb_avail[2] = 0; r.umb_segment = SegF000; r.success = 1;
        end else if (umb_avail[3]) begin
          umb_avail[3] = 0; r.umb_segment = SegD000; r.success = 1;
        end else r.error_code = ErrNoUmb;
      end
      MODE_UMB_REL: begin
        if (!umb_avail[0] && seg == SegC000) begin umb_avail[0] = 1; r.success = 1; end
        else if (!umb_avail[1] && seg == SegA000) begin umb_avail[1] = 1; r.success = 1; end
        else if (!umb_avail[2] && seg == SegF000) begin umb_avail[2] = 1; r.success = 1; end
        else if (!umb_avail[3] && seg == SegD000) begin umb_avail[3] = 1; r.success = 1; end
        else r.error_code = ErrBadUmb;
      end
      default: r.error_code = ErrUnimpl;
    endcase
    r.a20_on = (a20_depth != 0);
    return r;
  endfunction

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // one request: hold until accepted, predict, then maybe open a gap
  task automatic send_request(logic [4:0] mode, logic [15:0] h, logic [15:0] sz,
                              logic [15:0] paras, logic [15:0] seg,
                              bit typed = 0, bit ok = 0, logic [3:0] err = ErrNone);
    rsp_t r;
    s_axis_tdata <= {3'b0, seg, paras, sz, h, mode};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    r = serve_request(mode, h, sz, paras, seg);
    if (typed) begin
      r.success = ok;
      r.error_code = err;
    end
    pending_rsp.push_back(r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  // wait for all results, then let the block go idle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (ReqCycles + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTotalKb: total_kb_r = val;
      RegUmbA: umb_a_en = val[0];
      default: umb_cf_en = val[0];
    endcase
  endtask

  function automatic logic [15:0] pick_handle();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(NumHandles + 1);
      2: return 16'd0;
      default: return 16'($urandom_range(1, NumHandles));
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [15:0] pick_seg();
    case ($urandom_range(0, 4))
      0: return SegC000;
      1: return SegA000;
      2: return SegF000;
      3: return SegD000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // random requests, weighted toward the handle table
  task automatic random_requests(int unsigned n);
    logic [4:0] mode;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: mode = 5'($urandom_range(17, 31));
        1: mode = MODE_INIT;
        2, 3: mode = 5'($urandom_range(MODE_HMA_REQ, MODE_QFREE));
        4, 5, 6: mode = MODE_ALLOC;
        7, 8: mode = MODE_FREE;
        9, 10: mode = MODE_LOCK;
        11, 12: mode = MODE_UNLOCK;
        13, 14: mode = MODE_INFO;
        15, 16: mode = MODE_RESIZE;
        17: mode = MODE_QFREE;
        18: mode = MODE_UMB_REQ;
        default: mode = MODE_UMB_REL;
      endcase
      send_request(mode, pick_handle(), pick_size(),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4095)),
                   pick_seg());
    end
  endtask

  // receiver stall pattern, result check, watchdog
  int unsigned rx_tick;
  int unsigned stall_pct;
  rsp_t        got_rsp;
  rsp_t        want_rsp;
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 400 == 0) stall_pct = $urandom_range(0, 3) * 25;
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no request or result moved for %0d cycles", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_rsp = rsp_t'(m_axis_tdata[$bits(rsp_t)-1:0]);
        if (pending_rsp.size() == 0) begin
          $display("unexpected result 0x%0h at %0t", m_axis_tdata, $time);
          mismatches++;
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (got_rsp.success != want_rsp.success)
            report("success", got_rsp.success, want_rsp.success);
          if (got_rsp.error_code != want_rsp.error_code)
            report("error_code", got_rsp.error_code, want_rsp.error_code);
          if (got_rsp.handle_out != want_rsp.handle_out)
            report("handle_out", got_rsp.handle_out, want_rsp.handle_out);
          if (got_rsp.free_kb != want_rsp.free_kb)
            report("free_kb", got_rsp.free_kb, want_rsp.free_kb);
          if (got_rsp.lock_count_out != want_rsp.lock_count_out)
            report("lock_count_out", got_rsp.lock_count_out, want_rsp.lock_count_out);
          if (got_rsp.free_handles != want_rsp.free_handles)
            report("free_handles", got_rsp.free_handles, want_rsp.free_handles);
          if (got_rsp.size_kb_out != want_rsp.size_kb_out)
            report("size_kb_out", got_rsp.size_kb_out, want_rsp.size_kb_out);
          if (got_rsp.a20_on != want_rsp.a20_on)
            report("a20_on", got_rsp.a20_on, want_rsp.a20_on);
          if (got_rsp.umb_segment != want_rsp.umb_segment)
            report("umb_segment", got_rsp.umb_segment, want_rsp.umb_segment);
          if (got_rsp.umb_max_paragraphs != want_rsp.umb_max_paragraphs)
            report("umb_max_paragraphs", got_rsp.umb_max_paragraphs,
                   want_rsp.umb_max_paragraphs);
        end
      end
    end
  end

  // directed table, run after reset with default registers
  dir_row_t dir_rows[] = '{
    '{MODE_A20_QRY,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_INFO,     16'd0,     16'd0,     16'd0,     16'd0,     1, 0, ErrBadHandle},
    '{MODE_FREE,     16'hFFFF,  16'd0,     16'd0,     16'd0,     1, 0, ErrBadHandle},
    '{MODE_ALLOC,    16'd0,     16'hFFFF,  16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_ALLOC,    16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_QFREE,    16'd0,     16'd0,     16'd0,     16'd0,     0, 0, ErrNone},
    '{MODE_LOCK,     16'd1,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_RESIZE,   16'd1,     16'd5,     16'd0,     16'd0,     1, 0, ErrLocked},
    '{MODE_UNLOCK,   16'd1,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_UNLOCK,   16'd1,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_RESIZE,   16'd2,     16'h8000,  16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_INFO,     16'd2,     16'd0,     16'd0,     16'd0,     0, 0, ErrNone},
    '{MODE_LOCK,     16'd1,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_FREE,     16'd1,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_HMA_REQ,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_HMA_REQ,  16'd0,     16'd0,     16'd0,     16'd0,     1, 0, ErrHmaUsed},
    '{MODE_HMA_REL,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_HMA_REL,  16'd0,     16'd0,     16'd0,     16'd0,     1, 0, ErrHmaFree},
    '{MODE_A20_LDIS, 16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_A20_LEN,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_A20_GEN,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_A20_GDIS, 16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'h1000,  16'd0,     1, 0, ErrSmallerUmb},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'h0FFF,  16'd0,     1, 1, ErrNone},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'd0,     16'd0,     1, 1, ErrNone},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'd1,     16'd0,     1, 1, ErrNone},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'd1,     16'd0,     1, 1, ErrNone},
    '{MODE_UMB_REQ,  16'd0,     16'd0,     16'hFFFF,  16'd0,     1, 0, ErrNoUmb},
    '{MODE_UMB_REL,  16'd0,     16'd0,     16'd0,     SegC000,   1, 1, ErrNone},
    '{MODE_UMB_REL,  16'd0,     16'd0,     16'd0,     SegC000,   1, 0, ErrBadUmb},
    '{MODE_UMB_REL,  16'd0,     16'd0,     16'd0,     16'hFFFF,  1, 0, ErrBadUmb},
    '{5'd17,         16'd0,     16'd0,     16'd0,     16'd0,     1, 0, ErrUnimpl},
    '{5'd31,         16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  1, 0, ErrUnimpl}
  };

  // register settings per phase: total_kb, A000 enable, C000/F000 enable
  logic [15:0] phase_total [4] = '{16'd8192, 16'd0, 16'hFFFF, 16'd3000};
  bit          phase_a [4] = '{1, 0, 1, 0};
  bit          phase_cf [4] = '{1, 0, 0, 1};

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    cfg_we_i = 0;
    cfg_idx_i = RegTotalKb;
    cfg_data_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    rx_tick = 0;
    stall_pct = 0;
    burst_left = 5;
    total_kb_r = 16'd8192;
    umb_a_en = 1;
    umb_cf_en = 1;
    table_init();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].mode, dir_rows[i].handle, dir_rows[i].size_kb,
                   dir_rows[i].paras, dir_rows[i].seg, dir_rows[i].typed,
                   dir_rows[i].ok, dir_rows[i].err);

    for (int p = 0; p < 4; p++) begin
      // sender holds off until the block has nothing left in flight
      drain();
      write_reg(RegTotalKb, (p == 3) ? 16'($urandom_range(0, 65535)) : phase_total[p]);
      write_reg(RegUmbA, 16'(phase_a[p]));
      write_reg(RegUmbCf, 16'(phase_cf[p]));
      send_request(MODE_INIT, 0, 0, 0, 0);
      // fill the table past its end, then mixed traffic
      for (int k = 0; k < NumHandles + 2; k++)
        send_request(MODE_ALLOC, pick_handle(), pick_size(), 0, 0);
      random_requests(60);
      if (p == 1) begin
        // drive lock count and nesting counter into saturation
        for (int k = 0; k < 258; k++) begin
          send_request(MODE_LOCK, 16'd1, 0, 0, 0);
          send_request(MODE_A20_LEN, 0, 0, 0, 0);
        end
        send_request(MODE_INFO, 16'd1, 0, 0, 0);
      end
      random_requests(30);
    end

    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- xms_handle_manager.f -----
+incdir+rtl
rtl/xms_pkg.sv
rtl/xms_datapath.sv
rtl/xms_ctrl.sv
rtl/xms_handle_manager.sv
rtl/xms_checker.sv
dv/xms_handle_manager_tb.sv
